>>> rtl/tme_pkg.sv
// Shared types and codes for the trimmed mean engine.
`default_nettype none
package tme_pkg;

	localparam int SampleW = 32;
	localparam int TrimW   = 16;
	localparam int KeptW   = 7;

	typedef enum logic [1:0] {
		FUNC_ADD    = 2'd0,
		FUNC_FINISH = 2'd1,
		FUNC_CLEAR  = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_EMPTY    = 2'd1,
		STATUS_OVERFLOW = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TRIM,
		ST_SCAN,
		ST_DIVGO,
		ST_DIV
	} state_t;

	typedef struct packed {
		logic ins;
		logic shift;
	} cell_ctrl_t;

endpackage
`default_nettype wire

>>> rtl/tme_cell.sv
// One cell of the sorted insertion chain.
`default_nettype none
module tme_cell import tme_pkg::*; #(
	parameter int CW  = 7,
	parameter int IDX = 0
) (
	input  wire logic                      clk,
	input  wire cell_ctrl_t                ctrl,
	input  wire logic [CW-1:0]             count,
	input  wire logic signed [SampleW-1:0] new_val,
	input  wire logic signed [SampleW-1:0] left_val,
	input  wire logic                      left_gt,
	input  wire logic signed [SampleW-1:0] right_val,
	output logic signed [SampleW-1:0]      val,
	output logic                           gt
);

	logic signed [SampleW-1:0] val_q;
	logic                      occupied;

	assign occupied = count > CW'(IDX);
	// An empty slot counts as larger than anything.
	assign gt       = !occupied || (val_q > new_val);
	assign val      = val_q;

	always_ff @(posedge clk) begin
		if (ctrl.ins && gt) begin
			val_q <= left_gt ? left_val : new_val;
		end else if (ctrl.shift) begin
			val_q <= right_val;
		end
	end

endmodule
`default_nettype wire

>>> rtl/tme_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module tme_div #(
	parameter int SW = 38,
	parameter int CW = 7
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [SW-1:0] dividend,
	input  wire logic [CW-1:0] divisor,
	output logic               done,
	output logic [SW-1:0]      quotient
);

	localparam int NW = $clog2(SW + 1);

	logic [SW-1:0] dq_q;
	logic [CW-1:0] rem_q;
	logic [NW-1:0] left_q;
	logic          run_q;
	logic          done_q;
	logic [CW:0]   trial;
	logic          take;

	assign trial    = {rem_q, dq_q[SW-1]};
	assign take     = trial >= {1'b0, divisor};
	assign done     = done_q;
	assign quotient = dq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			left_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				left_q <= NW'(SW);
			end else if (run_q) begin
				left_q <= left_q - NW'(1);
				if (left_q == NW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
		end else if (run_q) begin
			rem_q <= take ? CW'(trial - {1'b0, divisor}) : CW'(trial);
			dq_q  <= {dq_q[SW-2:0], take};
		end
	end

endmodule
`default_nettype wire

>>> rtl/trimmed_mean_engine.sv
// Top level: sorted sample chain, trim window scan and mean divider.
// Add and clear requests may follow back to back.
// Finish on an empty or overflowed group reports in the cycle after acceptance.
// Otherwise finish forms k in ST_TRIM, shifts n-k cells out of the chain in ST_SCAN,
// starts the divider, then gets one divider bit a cycle (SW = 32+clog2(CAPACITY) bits).
// The receiver cannot stall; reset clears the count, overflow flag and trim fraction.
`default_nettype none
module trimmed_mean_engine import tme_pkg::*; #(
	parameter int CAPACITY = 64
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire logic [1:0]                func,
	input  wire logic signed [SampleW-1:0] sample,
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [TrimW-1:0]          cfg_data,
	output logic                           done,
	output logic signed [SampleW-1:0]      mean,
	output logic [1:0]                     status,
	output logic [KeptW-1:0]               kept_count
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int SW = SampleW + $clog2(CAPACITY);

	state_t                    state_q, state_d;
	cell_ctrl_t                ctrl;
	logic                      accept;
	logic                      full;
	logic [TrimW-1:0]          trim_q;
	logic [CW-1:0]             count_q;
	logic                      ovf_q;
	logic [CW-1:0]             n_q;
	logic [CW-1:0]             k_q;
	logic [CW-1:0]             j_q;
	logic [CW-1:0]             hi;
	logic [CW-1:0]             kept;
	logic [CW+TrimW-1:0]       prod;
	logic signed [SW-1:0]      sum_q;
	logic [SW-1:0]             sum_mag;
	logic                      neg_q;
	logic                      div_start;
	logic                      div_done;
	logic [SW-1:0]             quot;
	logic [SampleW-1:0]        quot_lo;
	logic                      done_q;
	logic signed [SampleW-1:0] mean_q;
	logic [1:0]                status_q;
	logic [KeptW-1:0]          kept_q;

	logic signed [SampleW-1:0] cell_val [CAPACITY];
	logic                      cell_gt  [CAPACITY];

	assign accept    = start && !busy;
	assign full      = count_q == CW'(CAPACITY);
	assign cfg_ready = 1'b1;

	// Trim window: keep indices k .. n-k-1 of the sorted chain.
	assign prod = (CW + TrimW)'(n_q) * (CW + TrimW)'(trim_q);
	assign hi   = n_q - k_q;
	assign kept = hi - k_q;

	// Insertion chain: every cell compares against the new sample at once and
	// the larger part of the row moves one slot right. During a scan the row
	// moves left and cell 0 feeds the accumulator.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [SampleW-1:0] lv;
		logic signed [SampleW-1:0] rv;
		logic                      lg;
		if (i == 0) begin : g_first
			assign lv = sample;
			assign lg = 1'b0;
		end else begin : g_mid
			assign lv = cell_val[i-1];
			assign lg = cell_gt[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign rv = cell_val[i];
		end else begin : g_inner
			assign rv = cell_val[i+1];
		end
		tme_cell #(.CW(CW), .IDX(i)) u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.count    (count_q),
			.new_val  (sample),
			.left_val (lv),
			.left_gt  (lg),
			.right_val(rv),
			.val      (cell_val[i]),
			.gt       (cell_gt[i])
		);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && func == FUNC_FINISH && !ovf_q && count_q != '0) begin
					state_d = ST_TRIM;
				end
			end
			ST_TRIM:  state_d = ST_SCAN;
			ST_SCAN: begin
				if (j_q == hi - CW'(1)) begin
					state_d = ST_DIVGO;
				end
			end
			ST_DIVGO: state_d = ST_DIV;
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		busy       = state_q != ST_IDLE;
		ctrl.ins   = accept && func == FUNC_ADD && !full;
		ctrl.shift = state_q == ST_SCAN;
		div_start  = state_q == ST_DIVGO;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			trim_q  <= '0;
			count_q <= '0;
			ovf_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				trim_q <= cfg_data;
			end
			if (accept) begin
				case (func)
					FUNC_ADD: begin
						// Drop the sample once full and remember the overflow.
						if (full) begin
							ovf_q <= 1'b1;
						end else begin
							count_q <= count_q + CW'(1);
						end
					end
					FUNC_FINISH: begin
						count_q <= '0;
						ovf_q   <= 1'b0;
						if (ovf_q || count_q == '0) begin
							done_q <= 1'b1;
						end
					end
					FUNC_CLEAR: begin
						count_q <= '0;
						ovf_q   <= 1'b0;
					end
					default: ;
				endcase
			end
			if (state_q == ST_DIV && div_done) begin
				done_q <= 1'b1;
			end
		end
	end

	// Datapath registers: window bounds, accumulator, result.
	always_ff @(posedge clk) begin
		if (accept && func == FUNC_FINISH) begin
			n_q      <= count_q;
			mean_q   <= '0;
			kept_q   <= '0;
			status_q <= ovf_q ? STATUS_OVERFLOW : STATUS_EMPTY;
		end
		if (state_q == ST_TRIM) begin
			k_q   <= CW'(prod >> (TrimW + 1));
			j_q   <= '0;
			sum_q <= '0;
		end
		if (state_q == ST_SCAN) begin
			j_q <= j_q + CW'(1);
			if (j_q >= k_q) begin
				sum_q <= sum_q + SW'(cell_val[0]);
			end
		end
		if (state_q == ST_DIVGO) begin
			neg_q <= sum_q[SW-1];
		end
		if (state_q == ST_DIV && div_done) begin
			mean_q   <= neg_q ? -quot_lo : quot_lo;
			status_q <= STATUS_OK;
			kept_q   <= KeptW'(kept);
		end
	end

	assign sum_mag = sum_q[SW-1] ? -sum_q : sum_q;
	assign quot_lo = quot[SampleW-1:0];

	tme_div #(.SW(SW), .CW(CW)) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(sum_mag),
		.divisor (kept),
		.done    (div_done),
		.quotient(quot)
	);

	assign done       = done_q;
	assign mean       = mean_q;
	assign status     = status_q;
	assign kept_count = kept_q;

endmodule
`default_nettype wire
